// ===== rtl/core/kptl_pkg.sv =====
// Shared types and constants for the kerning pair table loader and lookup.
// Depends on nothing; imported by every module of the block but kptl_pair_ram.
package kptl_pkg;

  // Store capacity and derived widths
  localparam int MAX_PAIRS = 1024;
  localparam int PAIR_AW   = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
  localparam int PCNT_W    = $clog2(MAX_PAIRS + 1);
  localparam int PAIR_W    = 48;

  // Command kinds
  typedef enum logic [1:0] {
    KIND_RESTART = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_QUERY   = 2'd2,
    KIND_UNUSED  = 2'd3
  } kptl_kind_t;

  // Load status codes
  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_BAD_VERSION = 2'd1;
  localparam logic [1:0] ST_DROPPED     = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE  = 2'd3;

  // Command payload
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] left_glyph;
    logic [15:0] right_glyph;
  } kptl_in_t;

  // Result payload
  typedef struct packed {
    logic signed [15:0] kern_value;
    logic               found;
    logic [1:0]         status;
  } kptl_out_t;

  // One stored pair
  typedef struct packed {
    logic [15:0] left_glyph;
    logic [15:0] right_glyph;
    logic [15:0] value;
  } kptl_pair_t;

  // Store write request from the parser
  typedef struct packed {
    logic               en;
    logic [PAIR_AW-1:0] addr;
    kptl_pair_t         data;
  } kptl_wr_t;

endpackage

// ===== rtl/core/kptl_pair_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module kptl_pair_ram #(
  parameter int DATA_W = 48,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/kptl_parser.sv =====
// Byte-stream parser for the kerning table: assembles words, walks headers,
// issues pair writes to the store and keeps the load status. Uses kptl_pkg.
module kptl_parser
  import kptl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              restart,
  input  logic              byte_en,
  input  logic [7:0]        data_byte,
  output kptl_wr_t          wr,
  output logic [PCNT_W-1:0] pair_count,
  output logic [1:0]        status
);

  typedef enum logic [2:0] {
    PH_MAIN,
    PH_SUB,
    PH_PAIR,
    PH_DONE,
    PH_HALT
  } phase_t;

  phase_t             phase, phase_next;
  logic [2:0]         hw_idx, hw_idx_next;
  logic               held_valid;
  logic [7:0]         held_byte;
  logic [31:0]        partial, partial_next;
  logic [15:0]        sub_left, sub_left_next;
  logic [15:0]        pairs_left, pairs_left_next;
  logic [1:0]         err, err_next;
  logic [PCNT_W-1:0]  pair_count_next;
  logic               active;
  logic               take;
  logic [15:0]        word;
  logic [15:0]        sub_dec;
  logic [15:0]        pairs_dec;

  assign active    = (phase != PH_DONE) && (phase != PH_HALT);
  assign take      = byte_en && active && held_valid;
  assign word      = {held_byte, data_byte};
  assign sub_dec   = sub_left - 16'd1;
  assign pairs_dec = pairs_left - 16'd1;

  // Word handling: header walk and pair assembly
  always_comb begin
    phase_next      = phase;
    hw_idx_next     = hw_idx;
    partial_next    = partial;
    sub_left_next   = sub_left;
    pairs_left_next = pairs_left;
    err_next        = err;
    pair_count_next = pair_count;
    wr.en           = 1'b0;
    wr.addr         = pair_count[PAIR_AW-1:0];
    wr.data         = {partial[31:16], partial[15:0], word};
    if (take) begin
      unique case (phase)
        PH_MAIN: begin
          if (hw_idx == 3'd0) begin
            hw_idx_next = 3'd1;
          end else begin
            sub_left_next = word;
            hw_idx_next   = 3'd0;
            phase_next    = (word == 16'd0) ? PH_DONE : PH_SUB;
          end
        end
        PH_SUB: begin
          // version in word 0, checked when the coverage word arrives
          if (hw_idx == 3'd2 && partial != 32'd0) begin
            err_next   = ST_BAD_VERSION;
            phase_next = PH_HALT;
          end else begin
            if (hw_idx == 3'd0) begin
              partial_next = {16'd0, word};
            end
            if (hw_idx == 3'd3) begin
              pairs_left_next = word;
            end
            if (hw_idx >= 3'd6) begin
              sub_left_next = sub_dec;
              hw_idx_next   = 3'd0;
              partial_next  = 32'd0;
              if (pairs_left != 16'd0) begin
                phase_next = PH_PAIR;
              end else begin
                phase_next = (sub_dec == 16'd0) ? PH_DONE : PH_SUB;
              end
            end else begin
              hw_idx_next = hw_idx + 3'd1;
            end
          end
        end
        PH_PAIR: begin
          if (hw_idx == 3'd0) begin
            partial_next = {word, 16'd0};
            hw_idx_next  = 3'd1;
          end else if (hw_idx == 3'd1) begin
            partial_next = {partial[31:16], word};
            hw_idx_next  = 3'd2;
          end else begin
            if (pair_count < PCNT_W'(MAX_PAIRS)) begin
              wr.en           = 1'b1;
              pair_count_next = pair_count + PCNT_W'(1);
            end else if (err == ST_OK) begin
              err_next = ST_DROPPED;
            end
            partial_next    = 32'd0;
            hw_idx_next     = 3'd0;
            pairs_left_next = pairs_dec;
            if (pairs_dec == 16'd0) begin
              phase_next = (sub_left == 16'd0) ? PH_DONE : PH_SUB;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // State registers; restart clears all but the store
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      phase      <= PH_MAIN;
      hw_idx     <= 3'd0;
      held_valid <= 1'b0;
      held_byte  <= 8'd0;
      partial    <= 32'd0;
      sub_left   <= 16'd0;
      pairs_left <= 16'd0;
      err        <= ST_OK;
      pair_count <= '0;
    end else begin
      if (byte_en && active) begin
        held_valid <= !held_valid;
        if (!held_valid) begin
          held_byte <= data_byte;
        end
      end
      phase      <= phase_next;
      hw_idx     <= hw_idx_next;
      partial    <= partial_next;
      sub_left   <= sub_left_next;
      pairs_left <= pairs_left_next;
      err        <= err_next;
      pair_count <= pair_count_next;
    end
  end

  // Error code wins over an unfinished load
  always_comb begin
    if (err != ST_OK) begin
      status = err;
    end else if (phase != PH_DONE) begin
      status = ST_INCOMPLETE;
    end else begin
      status = ST_OK;
    end
  end

endmodule

// ===== rtl/core/kptl_scan.sv =====
// Query sequencer: reads stored pairs in load order, one per cycle, and
// reports the first match. Uses kptl_pkg; drives the RAM read port.
module kptl_scan
  import kptl_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [15:0]        left_glyph,
  input  logic [15:0]        right_glyph,
  input  logic [PCNT_W-1:0]  count,
  input  logic [1:0]         status_in,
  output logic               rd_en,
  output logic [PAIR_AW-1:0] rd_addr,
  input  kptl_pair_t         rd_data,
  output logic               busy,
  output logic               done,
  output kptl_out_t          result
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t            state;
  logic [PCNT_W-1:0] idx;
  logic [PCNT_W-1:0] limit;
  logic [15:0]       key_l;
  logic [15:0]       key_r;
  logic [1:0]        status_q;
  logic              pend;
  logic              pend_last;
  logic              hit;

  // Read issue while entries remain
  assign rd_en   = (state == S_RUN) && (idx != limit);
  assign rd_addr = idx[PAIR_AW-1:0];
  assign busy    = (state == S_RUN);
  assign hit     = (rd_data.left_glyph == key_l) && (rd_data.right_glyph == key_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          pend <= 1'b0;
          if (go) begin
            key_l    <= left_glyph;
            key_r    <= right_glyph;
            status_q <= status_in;
            limit    <= count;
            idx      <= '0;
            if (count == '0) begin
              done              <= 1'b1;
              result.kern_value <= 16'sd0;
              result.found      <= 1'b0;
              result.status     <= status_in;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          pend      <= rd_en;
          pend_last <= (idx == limit - PCNT_W'(1));
          if (rd_en) begin
            idx <= idx + PCNT_W'(1);
          end
          // compare the entry read last cycle
          if (pend && hit) begin
            done              <= 1'b1;
            result.kern_value <= rd_data.value;
            result.found      <= 1'b1;
            result.status     <= status_q;
            state             <= S_IDLE;
          end else if (pend && pend_last) begin
            done              <= 1'b1;
            result.kern_value <= 16'sd0;
            result.found      <= 1'b0;
            result.status     <= status_q;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/kern_pair_table_load_lookup_core.sv =====
// Top level of the kerning pair table loader and lookup.
// Depends on kptl_pkg, kptl_parser, kptl_scan and kptl_pair_ram.
//
// Usage: a command transfers at a rising edge with start high and busy low.
// cmd.kind selects restart (clear load state), table byte, or lookup query;
// kind 3 is ignored. Table bytes are big-endian words of a kerning table;
// each completed left/right/value triple is written to a 1024-entry pair
// RAM in load order until it is full, and later pairs are dropped. Restarts
// and bytes give no result. A query scans the stored pairs through the RAM
// read port, one entry per cycle. With nothing stored the result comes
// without a scan; else the scan stops at the first match or after the last
// stored pair. Busy is high while the scan runs, so a query holds off
// further commands until its result.
// The result shows on result for exactly one cycle with done high; the
// receiver cannot stall it. Reset clears the load state (pair store contents
// are left as is and never read before written) and aborts any scan.
module kern_pair_table_load_lookup_core
  import kptl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  kptl_in_t  cmd,
  output logic      done,
  output kptl_out_t result
);

  logic              accept;
  logic              restart;
  logic              byte_en;
  logic              query;
  kptl_wr_t          wr;
  logic [PCNT_W-1:0] pair_count;
  logic [1:0]        status;
  logic              rd_en;
  logic [PAIR_AW-1:0] rd_addr;
  kptl_pair_t        rd_data;

  // Command decode
  assign accept  = start && !busy;
  assign restart = accept && (cmd.kind == KIND_RESTART);
  assign byte_en = accept && (cmd.kind == KIND_BYTE);
  assign query   = accept && (cmd.kind == KIND_QUERY);

  kptl_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .byte_en    (byte_en),
    .data_byte  (cmd.data_byte),
    .wr         (wr),
    .pair_count (pair_count),
    .status     (status)
  );

  kptl_pair_ram #(
    .DATA_W (PAIR_W),
    .DEPTH  (MAX_PAIRS),
    .ADDR_W (PAIR_AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kptl_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .go          (query),
    .left_glyph  (cmd.left_glyph),
    .right_glyph (cmd.right_glyph),
    .count       (pair_count),
    .status_in   (status),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .busy        (busy),
    .done        (done),
    .result      (result)
  );

endmodule

// ===== rtl/core/kptl_checker.sv =====
// Port-level checks for the kerning pair table core, bound to the top level.
// Uses kptl_pkg.
module kptl_checker
  import kptl_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input kptl_in_t  cmd,
  input logic      done,
  input kptl_out_t result
);

  // A query transfer is followed by a scan or an immediate result
  a_query_follow: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.kind == KIND_QUERY) |=> (busy || done))
    else $error("query gave neither scan nor result");

  // Restarts and bytes produce no result
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.kind != KIND_QUERY) |=> !done)
    else $error("result without a query");

  // A result ends the scan
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result while still scanning");

  // Scan only ends with a result
  a_fell_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> done)
    else $error("scan ended without result");

  // A miss reports zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.kern_value == 16'sd0))
    else $error("miss with nonzero value");

endmodule

bind kern_pair_table_load_lookup_core kptl_checker u_kptl_checker (.*);
